/* src/cbdt_pkg.sv */
`timescale 1ns / 1ps
package cbdt_pkg;

  // default coordinate width, sizes carry one extra bit
  localparam int COORD_BITS_DEF = 12;

  // entries in the queue between classifier and accumulator
  localparam int QUEUE_DEPTH_DEF = 2;

  // pixel total width, saturating
  localparam int PIX_BITS = 32;

  // configuration register map
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEST_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_DEST_HEIGHT = 2'd1;

  // classified item: start, copied, four corners, clipped width and height
  function automatic int item_bits(input int coord_bits);
    return 2 + 4 * coord_bits + 2 * (coord_bits + 1);
  endfunction

endpackage

/* src/cbdt_front.sv */
`timescale 1ns / 1ps
module cbdt_front #(
  parameter int COORD_BITS = cbdt_pkg::COORD_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_stall,
  input  logic                               start_frame,
  input  logic                               damage_touched,
  input  logic [COORD_BITS-1:0]              dmg_left,
  input  logic [COORD_BITS-1:0]              dmg_top,
  input  logic [COORD_BITS-1:0]              dmg_right,
  input  logic [COORD_BITS-1:0]              dmg_bottom,
  input  logic [COORD_BITS:0]                source_width,
  input  logic [COORD_BITS:0]                source_height,
  input  logic [COORD_BITS-1:0]              offset_x,
  input  logic [COORD_BITS-1:0]              offset_y,
  input  logic [COORD_BITS:0]                dest_width,
  input  logic [COORD_BITS:0]                dest_height,
  output logic                               item_valid,
  input  logic                               item_full,
  output logic [cbdt_pkg::item_bits(COORD_BITS)-1:0] item_data
);
  import cbdt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SB = COORD_BITS + 1;
  localparam int IB = item_bits(COORD_BITS);
  localparam logic [SB-1:0] DEST_LIMIT = {1'b1, {CB{1'b0}}};
  localparam logic [SB-1:0] ONE = {{CB{1'b0}}, 1'b1};

  logic [SB-1:0] dw_eff, dh_eff;
  logic [SB-1:0] sw_m1, sh_m1;
  logic [CB-1:0] x1, y1, x2, y2;
  logic [SB-1:0] cw, ch, pos_x, pos_y, room_x, room_y, cw_c, ch_c;
  logic [SB-1:0] right_full, bottom_full;
  logic          copy;
  logic [IB-1:0] item_next;
  logic          fv;
  logic [IB-1:0] item;

  always_comb begin
    dw_eff = (dest_width > DEST_LIMIT) ? DEST_LIMIT : dest_width;
    dh_eff = (dest_height > DEST_LIMIT) ? DEST_LIMIT : dest_height;
    sw_m1  = source_width - ONE;
    sh_m1  = source_height - ONE;
    // clamp corners into the source
    x1 = ({1'b0, dmg_left} < source_width) ? dmg_left : sw_m1[CB-1:0];
    x2 = ({1'b0, dmg_right} < source_width) ? dmg_right : sw_m1[CB-1:0];
    y1 = ({1'b0, dmg_top} < source_height) ? dmg_top : sh_m1[CB-1:0];
    y2 = ({1'b0, dmg_bottom} < source_height) ? dmg_bottom : sh_m1[CB-1:0];
    cw = {1'b0, x2} - {1'b0, x1} + ONE;
    ch = {1'b0, y2} - {1'b0, y1} + ONE;
    // clip against the destination, no wrap past the edge
    pos_x  = {1'b0, offset_x} + {1'b0, x1};
    pos_y  = {1'b0, offset_y} + {1'b0, y1};
    room_x = (pos_x < dw_eff) ? dw_eff - pos_x : '0;
    room_y = (pos_y < dh_eff) ? dh_eff - pos_y : '0;
    cw_c   = (cw > room_x) ? room_x : cw;
    ch_c   = (ch > room_y) ? room_y : ch;
    copy = damage_touched && (source_width != '0) && (source_height != '0) &&
           ({1'b0, offset_x} < dw_eff) && ({1'b0, offset_y} < dh_eff) &&
           (x2 >= x1) && (y2 >= y1) && (cw_c != '0) && (ch_c != '0);
    right_full  = pos_x + cw_c - ONE;
    bottom_full = pos_y + ch_c - ONE;
    if (copy) begin
      item_next = {start_frame, 1'b1, pos_x[CB-1:0], pos_y[CB-1:0],
                   right_full[CB-1:0], bottom_full[CB-1:0], cw_c, ch_c};
    end else begin
      item_next = {start_frame, 1'b0, {(IB-2){1'b0}}};
    end
  end

  assign req_stall  = fv && item_full;
  assign item_valid = fv;
  assign item_data  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (!req_stall) begin
      fv <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!req_stall && req_valid) begin
      item <= item_next;
    end
  end

endmodule

/* src/cbdt_queue.sv */
`timescale 1ns / 1ps
module cbdt_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTB = $clog2(DEPTH + 1);
  localparam logic [PB-1:0] LAST = PB'(DEPTH - 1);
  localparam logic [CNTB-1:0] CNT_FULL = CNTB'(DEPTH);
  localparam logic [CNTB-1:0] CNT_ONE = CNTB'(1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PB-1:0]    wr_ptr, rd_ptr;
  logic [CNTB-1:0]  count;
  logic             do_push, do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_ONE;
      end else if (do_pop && !do_push) begin
        count <= count - CNT_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* src/cbdt_back.sv */
`timescale 1ns / 1ps
module cbdt_back #(
  parameter int COORD_BITS = cbdt_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic [cbdt_pkg::item_bits(COORD_BITS)-1:0] q_data,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output logic                  copied,
  output logic [COORD_BITS-1:0] blit_left,
  output logic [COORD_BITS-1:0] blit_top,
  output logic [COORD_BITS-1:0] blit_right,
  output logic [COORD_BITS-1:0] blit_bottom,
  output logic                  acc_valid,
  output logic [COORD_BITS-1:0] acc_left,
  output logic [COORD_BITS-1:0] acc_top,
  output logic [COORD_BITS-1:0] acc_right,
  output logic [COORD_BITS-1:0] acc_bottom,
  output logic [cbdt_pkg::PIX_BITS-1:0] acc_pixels
);
  import cbdt_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int SB = COORD_BITS + 1;
  localparam int PW = 2 * SB;

  logic          i_start, i_copied;
  logic [CB-1:0] i_bl, i_bt, i_br, i_bb;
  logic [SB-1:0] i_cw, i_ch;
  logic [PW-1:0] prod;
  logic [PW+PIX_BITS-1:0] prod_ext;

  // multiply stage
  logic                m_v, m_start, m_copied;
  logic [CB-1:0]       m_bl, m_bt, m_br, m_bb;
  logic [PIX_BITS-1:0] m_px;
  logic                m_ready, o_load;

  // output stage and accumulator
  logic                o_v, o_copied;
  logic [CB-1:0]       o_bl, o_bt, o_br, o_bb;
  logic                accum_valid;
  logic [CB-1:0]       accum_left, accum_top, accum_right, accum_bottom;
  logic [PIX_BITS-1:0] accum_pixel_total;

  logic                base_valid;
  logic [CB-1:0]       base_left, base_top, base_right, base_bottom;
  logic [PIX_BITS-1:0] base_total;
  logic [PIX_BITS:0]   sum;
  logic                valid_next;
  logic [CB-1:0]       left_next, top_next, right_next, bottom_next;
  logic [PIX_BITS-1:0] total_next;

  assign {i_start, i_copied, i_bl, i_bt, i_br, i_bb, i_cw, i_ch} = q_data;
  assign prod     = i_cw * i_ch;
  assign prod_ext = {{PIX_BITS{1'b0}}, prod};

  assign o_load  = m_v && (!o_v || !rsp_stall);
  assign m_ready = !m_v || o_load;
  assign q_pop   = q_valid && m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v <= 1'b0;
    end else if (m_ready) begin
      m_v <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_start  <= i_start;
      m_copied <= i_copied;
      m_bl     <= i_bl;
      m_bt     <= i_bt;
      m_br     <= i_br;
      m_bb     <= i_bb;
      m_px     <= prod_ext[PIX_BITS-1:0];
    end
  end

  always_comb begin
    // start of frame clears the running box before the merge
    base_valid  = m_start ? 1'b0 : accum_valid;
    base_left   = m_start ? '0 : accum_left;
    base_top    = m_start ? '0 : accum_top;
    base_right  = m_start ? '0 : accum_right;
    base_bottom = m_start ? '0 : accum_bottom;
    base_total  = m_start ? '0 : accum_pixel_total;
    sum = {1'b0, base_total} + {1'b0, m_px};
    valid_next  = base_valid;
    left_next   = base_left;
    top_next    = base_top;
    right_next  = base_right;
    bottom_next = base_bottom;
    total_next  = base_total;
    if (m_copied) begin
      valid_next = 1'b1;
      if (!base_valid) begin
        left_next   = m_bl;
        top_next    = m_bt;
        right_next  = m_br;
        bottom_next = m_bb;
        total_next  = m_px;
      end else begin
        left_next   = (m_bl < base_left) ? m_bl : base_left;
        top_next    = (m_bt < base_top) ? m_bt : base_top;
        right_next  = (m_br > base_right) ? m_br : base_right;
        bottom_next = (m_bb > base_bottom) ? m_bb : base_bottom;
        total_next  = sum[PIX_BITS] ? {PIX_BITS{1'b1}} : sum[PIX_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v               <= 1'b0;
      accum_valid       <= 1'b0;
      accum_left        <= '0;
      accum_top         <= '0;
      accum_right       <= '0;
      accum_bottom      <= '0;
      accum_pixel_total <= '0;
    end else begin
      if (!o_v || !rsp_stall) begin
        o_v <= m_v;
      end
      if (o_load) begin
        accum_valid       <= valid_next;
        accum_left        <= left_next;
        accum_top         <= top_next;
        accum_right       <= right_next;
        accum_bottom      <= bottom_next;
        accum_pixel_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      o_copied <= m_copied;
      o_bl     <= m_bl;
      o_bt     <= m_bt;
      o_br     <= m_br;
      o_bb     <= m_bb;
    end
  end

  assign rsp_valid   = o_v;
  assign copied      = o_copied;
  assign blit_left   = o_bl;
  assign blit_top    = o_bt;
  assign blit_right  = o_br;
  assign blit_bottom = o_bb;
  assign acc_valid   = accum_valid;
  assign acc_left    = accum_left;
  assign acc_top     = accum_top;
  assign acc_right   = accum_right;
  assign acc_bottom  = accum_bottom;
  assign acc_pixels  = accum_pixel_total;

  // an empty accumulator carries no box and no pixels
  a_empty_is_zero: assert property (@(posedge clk) disable iff (rst)
    !accum_valid |-> (accum_pixel_total == '0 && accum_left == '0 && accum_right == '0))
    else $error("empty accumulator holds stale values");

  // a held box is never inverted
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    accum_valid |-> (accum_left <= accum_right && accum_top <= accum_bottom))
    else $error("accumulated box inverted");

  // a copied rectangle always leaves the accumulator holding damage
  a_copy_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (o_load && m_copied) |=> accum_valid)
    else $error("copied rectangle not merged");

  // a request that copies nothing reports an all-zero rectangle
  a_nocopy_zero: assert property (@(posedge clk) disable iff (rst)
    (o_v && !o_copied) |-> (o_bl == '0 && o_bt == '0 && o_br == '0 && o_bb == '0))
    else $error("empty blit carries coordinates");

endmodule

/* src/clipped_blit_damage_tracker.sv */
`timescale 1ns / 1ps
// clipped blit damage tracker
// req channel: one blit request per beat (damage rectangle, touched flag,
//   source size, destination offset), taken when req_valid is high and
//   req_stall is low
// rsp channel: exactly one result per request, in order, offered while
//   rsp_valid is high and taken when rsp_stall is low; it holds the written
//   rectangle in destination coordinates and the running bounding box with
//   its saturating pixel total after this request
// cfg channel: dest_width / dest_height writes, cfg_ready is always high;
//   write only while no request is in flight
// throughput: one request per cycle sustained while rsp_stall is low;
//   the classifier, queue, multiply stage and accumulator each move one
//   beat a cycle; the merge is a combinational min/max and saturating add
// a stalled receiver first fills the output register, then the multiply
//   stage and the queue, and only then raises req_stall
// reset: destination size returns to full range, the accumulator clears
//   and all stages empty
module clipped_blit_damage_tracker #(
  parameter int COORD_BITS  = cbdt_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = cbdt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cbdt_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS:0]           cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic                          start_frame,
  input  logic                          damage_touched,
  input  logic [COORD_BITS-1:0]         dmg_left,
  input  logic [COORD_BITS-1:0]         dmg_top,
  input  logic [COORD_BITS-1:0]         dmg_right,
  input  logic [COORD_BITS-1:0]         dmg_bottom,
  input  logic [COORD_BITS:0]           source_width,
  input  logic [COORD_BITS:0]           source_height,
  input  logic [COORD_BITS-1:0]         offset_x,
  input  logic [COORD_BITS-1:0]         offset_y,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic                          copied,
  output logic [COORD_BITS-1:0]         blit_left,
  output logic [COORD_BITS-1:0]         blit_top,
  output logic [COORD_BITS-1:0]         blit_right,
  output logic [COORD_BITS-1:0]         blit_bottom,
  output logic                          acc_valid,
  output logic [COORD_BITS-1:0]         acc_left,
  output logic [COORD_BITS-1:0]         acc_top,
  output logic [COORD_BITS-1:0]         acc_right,
  output logic [COORD_BITS-1:0]         acc_bottom,
  output logic [cbdt_pkg::PIX_BITS-1:0] acc_pixels
);
  import cbdt_pkg::*;

  localparam int IB = item_bits(COORD_BITS);
  // full-range destination after reset
  localparam logic [COORD_BITS:0] DEST_RESET = {1'b1, {COORD_BITS{1'b0}}};

  logic [COORD_BITS:0] dest_width, dest_height;

  // classified items between front and back
  logic          f_valid, q_full, q_valid, q_pop;
  logic [IB-1:0] f_data, q_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_width  <= DEST_RESET;
      dest_height <= DEST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEST_WIDTH:  dest_width  <= cfg_data;
        REG_DEST_HEIGHT: dest_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: clamp to source, clip to destination, classify
  cbdt_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .req_valid      (req_valid),
    .req_stall      (req_stall),
    .start_frame    (start_frame),
    .damage_touched (damage_touched),
    .dmg_left       (dmg_left),
    .dmg_top        (dmg_top),
    .dmg_right      (dmg_right),
    .dmg_bottom     (dmg_bottom),
    .source_width   (source_width),
    .source_height  (source_height),
    .offset_x       (offset_x),
    .offset_y       (offset_y),
    .dest_width     (dest_width),
    .dest_height    (dest_height),
    .item_valid     (f_valid),
    .item_full      (q_full),
    .item_data      (f_data)
  );

  // short queue decoupling the two halves
  cbdt_queue #(
    .WIDTH (IB),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  // back: pixel count multiply, accumulator merge, output register
  cbdt_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_data      (q_data),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .copied      (copied),
    .blit_left   (blit_left),
    .blit_top    (blit_top),
    .blit_right  (blit_right),
    .blit_bottom (blit_bottom),
    .acc_valid   (acc_valid),
    .acc_left    (acc_left),
    .acc_top     (acc_top),
    .acc_right   (acc_right),
    .acc_bottom  (acc_bottom),
    .acc_pixels  (acc_pixels)
  );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import cbdt_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam logic [CB:0] DEST_FULL = 1 << CB;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 12;

  // one blit request beat, packed in port order
  typedef struct packed {
    logic          start;
    logic          touched;
    logic [CB-1:0] left;
    logic [CB-1:0] top;
    logic [CB-1:0] right;
    logic [CB-1:0] bottom;
    logic [CB:0]   src_w;
    logic [CB:0]   src_h;
    logic [CB-1:0] off_x;
    logic [CB-1:0] off_y;
  } blit_req_t;

  // one result beat: written rectangle plus running damage box
  typedef struct packed {
    logic          copied;
    logic [CB-1:0] bl;
    logic [CB-1:0] bt;
    logic [CB-1:0] br;
    logic [CB-1:0] bb;
    logic          box_v;
    logic [CB-1:0] box_l;
    logic [CB-1:0] box_t;
    logic [CB-1:0] box_r;
    logic [CB-1:0] box_b;
    logic [31:0]   pixels;
  } blit_rsp_t;

  // directed row: typed rows carry their own expected result
  typedef struct packed {
    logic      typed;
    blit_req_t q;
    blit_rsp_t r;
  } blit_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_DEST_WIDTH;
  logic [CB:0]           cfg_data = '0;

  logic          req_valid = 1'b0;
  logic          req_stall;
  logic          start_frame = 1'b0;
  logic          damage_touched = 1'b0;
  logic [CB-1:0] dmg_left = '0;
  logic [CB-1:0] dmg_top = '0;
  logic [CB-1:0] dmg_right = '0;
  logic [CB-1:0] dmg_bottom = '0;
  logic [CB:0]   source_width = '0;
  logic [CB:0]   source_height = '0;
  logic [CB-1:0] offset_x = '0;
  logic [CB-1:0] offset_y = '0;

  logic          rsp_valid;
  logic          rsp_stall = 1'b0;
  logic          copied;
  logic [CB-1:0] blit_left, blit_top, blit_right, blit_bottom;
  logic          acc_valid;
  logic [CB-1:0] acc_left, acc_top, acc_right, acc_bottom;
  logic [31:0]   acc_pixels;

  // predictor state: destination size and the damage box so far
  logic [CB:0]   dest_w_cfg = DEST_FULL;
  logic [CB:0]   dest_h_cfg = DEST_FULL;
  logic          box_valid = 1'b0;
  logic [CB-1:0] box_left = '0, box_top = '0, box_right = '0, box_bottom = '0;
  logic [31:0]   box_pixels = '0;

  blit_rsp_t pending_q[$];
  int        n_errors = 0;
  int        cycle_count = 0;
  bit        in_quiet = 1'b0;
  bit        out_quiet = 1'b0;
  int        stall_run = 0;
  int        stall_len;

  clipped_blit_damage_tracker DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .start_frame(start_frame), .damage_touched(damage_touched),
    .dmg_left(dmg_left), .dmg_top(dmg_top), .dmg_right(dmg_right),
    .dmg_bottom(dmg_bottom),
    .source_width(source_width), .source_height(source_height),
    .offset_x(offset_x), .offset_y(offset_y),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .copied(copied),
    .blit_left(blit_left), .blit_top(blit_top), .blit_right(blit_right),
    .blit_bottom(blit_bottom),
    .acc_valid(acc_valid), .acc_left(acc_left), .acc_top(acc_top),
    .acc_right(acc_right), .acc_bottom(acc_bottom), .acc_pixels(acc_pixels)
  );

  always #6 clk = ~clk;

  // watchdog, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_gap(input bit quiet);
    int k;
    k = $urandom_range(0, 99);
    if (quiet || k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // clip, place and merge one request, exactly as the block should
  function automatic blit_rsp_t apply_blit(input blit_req_t q);
    logic [CB:0]   dw, dh, x1, y1, x2, y2, cw, ch, rw, rh;
    logic [CB+1:0] px0, py0, ex, ey;
    logic [31:0]   area;
    blit_rsp_t     o;
    o = '0;
    // oversized destination registers act as the full coordinate range
    dw = (dest_w_cfg > DEST_FULL) ? DEST_FULL : dest_w_cfg;
    dh = (dest_h_cfg > DEST_FULL) ? DEST_FULL : dest_h_cfg;
    if (q.start) begin
      box_valid = 1'b0;
      box_left = '0;
      box_top = '0;
      box_right = '0;
      box_bottom = '0;
      box_pixels = '0;
    end
    if (q.touched && q.src_w != 0 && q.src_h != 0 && q.off_x < dw && q.off_y < dh) begin
      // clamp the damage corners into the source
      x1 = (q.left < q.src_w) ? q.left : q.src_w - 1'b1;
      y1 = (q.top < q.src_h) ? q.top : q.src_h - 1'b1;
      x2 = (q.right < q.src_w) ? q.right : q.src_w - 1'b1;
      y2 = (q.bottom < q.src_h) ? q.bottom : q.src_h - 1'b1;
      // reversed corners copy nothing
      if (x2 >= x1 && y2 >= y1) begin
        cw = x2 - x1 + 1'b1;
        ch = y2 - y1 + 1'b1;
        px0 = q.off_x + x1;
        py0 = q.off_y + y1;
        // room to the destination edge, zero when already past it
        rw = (px0 < dw) ? dw - px0 : '0;
        rh = (py0 < dh) ? dh - py0 : '0;
        if (cw > rw) cw = rw;
        if (ch > rh) ch = rh;
        if (cw != 0 && ch != 0) begin
          area = cw * ch;
          ex = px0 + cw - 1'b1;
          ey = py0 + ch - 1'b1;
          o.copied = 1'b1;
          o.bl = px0[CB-1:0];
          o.bt = py0[CB-1:0];
          o.br = ex[CB-1:0];
          o.bb = ey[CB-1:0];
          if (!box_valid) begin
            box_valid = 1'b1;
            box_left = o.bl;
            box_top = o.bt;
            box_right = o.br;
            box_bottom = o.bb;
            box_pixels = area;
          end else begin
            if (o.bl < box_left) box_left = o.bl;
            if (o.bt < box_top) box_top = o.bt;
            if (o.br > box_right) box_right = o.br;
            if (o.bb > box_bottom) box_bottom = o.bb;
            // pixel total saturates instead of wrapping
            if (box_pixels > 32'hFFFF_FFFF - area) box_pixels = '1;
            else box_pixels = box_pixels + area;
          end
        end
      end
    end
    o.box_v = box_valid;
    o.box_l = box_left;
    o.box_t = box_top;
    o.box_r = box_right;
    o.box_b = box_bottom;
    o.pixels = box_pixels;
    return o;
  endfunction

  function automatic blit_req_t mk_req(input logic s, input logic t, input int l,
                                       input int tp, input int r, input int b,
                                       input int sw, input int sh, input int ox,
                                       input int oy);
    blit_req_t q;
    q.start = s;
    q.touched = t;
    q.left = l;
    q.top = tp;
    q.right = r;
    q.bottom = b;
    q.src_w = sw;
    q.src_h = sh;
    q.off_x = ox;
    q.off_y = oy;
    return q;
  endfunction

  function automatic blit_rsp_t mk_rsp(input logic c, input int l, input int tp,
                                       input int r, input int b, input logic v,
                                       input int al, input int at, input int ar,
                                       input int ab, input logic [31:0] pix);
    blit_rsp_t o;
    o.copied = c;
    o.bl = l;
    o.bt = tp;
    o.br = r;
    o.bb = b;
    o.box_v = v;
    o.box_l = al;
    o.box_t = at;
    o.box_r = ar;
    o.box_b = ab;
    o.pixels = pix;
    return o;
  endfunction

  // source extent: full, tiny or anything
  function automatic logic [CB:0] pick_extent();
    int k;
    k = $urandom_range(0, 7);
    if (k == 0) return DEST_FULL;
    if (k == 1) return $urandom_range(1, 8);
    return $urandom_range(1, DEST_FULL);
  endfunction

  // random request; heavy ones are near full frame and never clear the box
  function automatic blit_req_t random_blit(input bit heavy);
    blit_req_t     q;
    logic [CB:0]   dw, dh;
    logic [CB-1:0] tmp;
    int            k;
    dw = (dest_w_cfg > DEST_FULL) ? DEST_FULL : dest_w_cfg;
    dh = (dest_h_cfg > DEST_FULL) ? DEST_FULL : dest_h_cfg;
    k = $urandom_range(0, 99);
    if (heavy) begin
      q = mk_req(1'b0, 1'b1, $urandom_range(0, 3), $urandom_range(0, 3),
                 $urandom_range(DEST_FULL - 4, DEST_FULL - 1),
                 $urandom_range(DEST_FULL - 4, DEST_FULL - 1),
                 DEST_FULL, DEST_FULL, $urandom_range(0, 3), $urandom_range(0, 3));
    end else if (k < 75) begin
      // well formed: corners inside the source, origin on the destination
      q.start = ($urandom_range(0, 15) == 0);
      q.touched = ($urandom_range(0, 19) != 0);
      q.src_w = pick_extent();
      q.src_h = pick_extent();
      q.left = $urandom_range(0, q.src_w - 1);
      q.top = $urandom_range(0, q.src_h - 1);
      // now and then run past the source so the clamp kicks in
      q.right = ($urandom_range(0, 7) == 0) ? $urandom_range(q.left, DEST_FULL - 1)
                                             : $urandom_range(q.left, q.src_w - 1);
      q.bottom = ($urandom_range(0, 7) == 0) ? $urandom_range(q.top, DEST_FULL - 1)
                                              : $urandom_range(q.top, q.src_h - 1);
      if ($urandom_range(0, 15) == 0) begin
        tmp = q.left;
        q.left = q.right;
        q.right = tmp;
      end
      q.off_x = (dw == 0 || $urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, dw - 1);
      q.off_y = (dh == 0 || $urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, dh - 1);
    end else begin
      // noise: every field random, sizes kept in range
      q = {$urandom, $urandom, $urandom, $urandom};
      q.src_w = $urandom_range(0, DEST_FULL);
      q.src_h = $urandom_range(0, DEST_FULL);
    end
    return q;
  endfunction

  function automatic string show_rsp(input blit_rsp_t r);
    return $sformatf("copied=%0d blit=(%0d,%0d,%0d,%0d) box=%0d (%0d,%0d,%0d,%0d) pix=%0d",
                     r.copied, r.bl, r.bt, r.br, r.bb, r.box_v, r.box_l, r.box_t,
                     r.box_r, r.box_b, r.pixels);
  endfunction

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("error: %s", msg);
  endtask

  // drive one request beat and queue its expected result once taken
  task automatic send_blit(input blit_req_t q, input logic typed, input blit_rsp_t want);
    int        gap;
    blit_rsp_t pred;
    gap = pick_gap(in_quiet);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    {start_frame, damage_touched, dmg_left, dmg_top, dmg_right, dmg_bottom,
     source_width, source_height, offset_x, offset_y} <= q;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    // beat taken at this edge
    pred = apply_blit(q);
    pending_q.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // both size registers, back to back, only while the block is idle
  task automatic write_dest(input logic [CB:0] w, input logic [CB:0] h);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? REG_DEST_WIDTH : REG_DEST_HEIGHT;
      cfg_data <= (i == 0) ? w : h;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      if (i == 0) dest_w_cfg = w;
      else dest_h_cfg = h;
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver: runs of stall and no stall, quiet phases never stall
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (rsp_stall) begin
      rsp_stall <= 1'b0;
      stall_run <= $urandom_range(0, 10);
    end else begin
      stall_len = pick_gap(out_quiet);
      if (stall_len != 0) begin
        rsp_stall <= 1'b1;
        stall_run <= stall_len - 1;
      end else begin
        stall_run <= $urandom_range(0, 10);
      end
    end
  end

  // result checker: every taken beat against the oldest expectation
  always @(posedge clk) begin : result_check
    blit_rsp_t got, want;
    if (!rst && rsp_valid && !rsp_stall) begin
      got = {copied, blit_left, blit_top, blit_right, blit_bottom, acc_valid,
             acc_left, acc_top, acc_right, acc_bottom, acc_pixels};
      if (pending_q.size() == 0) begin
        flag_error({"result beat with none expected: ", show_rsp(got)});
      end else begin
        want = pending_q.pop_front();
        if (got !== want)
          flag_error({"expected ", show_rsp(want), " got ", show_rsp(got)});
      end
    end
  end

  initial begin : stimulus
    blit_row_t rows[$];
    blit_rsp_t none;
    int        dw_list[PHASES];
    int        dh_list[PHASES];
    int        n_list[PHASES];
    none = '0;

    // directed part, destination at its reset size of 4096 x 4096
    // nothing touched, all fields low after reset
    rows.push_back({1'b1, mk_req(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), none});
    // untouched damage with every other field at its top
    rows.push_back({1'b1, mk_req(0, 0, 4095, 4095, 4095, 4095, 4096, 4096, 4095, 4095),
                    none});
    // whole frame
    rows.push_back({1'b1, mk_req(1, 1, 0, 0, 4095, 4095, 4096, 4096, 0, 0),
                    mk_rsp(1, 0, 0, 4095, 4095, 1, 0, 0, 4095, 4095, 32'd16777216)});
    // corner pixel merged into the full box
    rows.push_back({1'b1, mk_req(0, 1, 4095, 4095, 4095, 4095, 4096, 4096, 0, 0),
                    mk_rsp(1, 4095, 4095, 4095, 4095, 1, 0, 0, 4095, 4095, 32'd16777217)});
    // new frame with only the corner pixel
    rows.push_back({1'b1, mk_req(1, 1, 4095, 4095, 4095, 4095, 4096, 4096, 0, 0),
                    mk_rsp(1, 4095, 4095, 4095, 4095, 1, 4095, 4095, 4095, 4095, 32'd1)});
    // reversed columns, then reversed rows: no copy, box kept
    rows.push_back({1'b1, mk_req(0, 1, 10, 0, 5, 0, 4096, 4096, 0, 0),
                    mk_rsp(0, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095, 32'd1)});
    rows.push_back({1'b1, mk_req(0, 1, 0, 10, 0, 5, 4096, 4096, 0, 0),
                    mk_rsp(0, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095, 32'd1)});
    // zero source width, then zero source height
    rows.push_back({1'b1, mk_req(0, 1, 0, 0, 4095, 4095, 0, 4096, 0, 0),
                    mk_rsp(0, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095, 32'd1)});
    rows.push_back({1'b1, mk_req(0, 1, 0, 0, 4095, 4095, 4096, 0, 0, 0),
                    mk_rsp(0, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095, 32'd1)});
    // offset plus clamped corner lands right on the edge: must not wrap
    rows.push_back({1'b1, mk_req(0, 1, 1, 0, 4095, 0, 4096, 4096, 4095, 0),
                    mk_rsp(0, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095, 32'd1)});
    rows.push_back({1'b1, mk_req(0, 1, 0, 1, 0, 4095, 4096, 4096, 0, 4095),
                    mk_rsp(0, 0, 0, 0, 0, 1, 4095, 4095, 4095, 4095, 32'd1)});
    // wide row at the last column clipped to one pixel
    rows.push_back({1'b1, mk_req(1, 1, 0, 0, 4095, 0, 4096, 1, 4095, 0),
                    mk_rsp(1, 4095, 0, 4095, 0, 1, 4095, 0, 4095, 0, 32'd1)});
    // damage beyond a small source, clamped
    rows.push_back({1'b0, mk_req(0, 1, 100, 0, 4095, 4095, 50, 50, 10, 20), none});
    // clear without a copy
    rows.push_back({1'b1, mk_req(1, 0, 5, 5, 9, 9, 100, 100, 3, 3), none});
    // clear together with a request that copies nothing
    rows.push_back({1'b1, mk_req(1, 1, 9, 9, 5, 5, 100, 100, 3, 3), none});
    // merges that grow the box, the third one clipped at the right edge
    rows.push_back({1'b0, mk_req(0, 1, 200, 300, 400, 500, 1024, 1024, 7, 9), none});
    rows.push_back({1'b0, mk_req(0, 1, 0, 0, 3, 3, 16, 16, 4000, 4000), none});
    rows.push_back({1'b0, mk_req(0, 1, 2000, 1000, 4095, 4095, 4096, 2048, 1000, 100),
                    none});
    rows.push_back({1'b0, mk_req(0, 1, 0, 0, 0, 0, 1, 1, 0, 0), none});

    // phase plan: destination size and request count
    dw_list[0] = 8191; dh_list[0] = 8191; n_list[0] = 300;  // saturation run
    dw_list[1] = 1;    dh_list[1] = 1;    n_list[1] = 100;
    dw_list[2] = 0;    dh_list[2] = 4096; n_list[2] = 60;
    dw_list[3] = 4096; dh_list[3] = 0;    n_list[3] = 60;
    dw_list[4] = 4096; dh_list[4] = 4096; n_list[4] = 200;
    dw_list[5] = 640;  dh_list[5] = 480;  n_list[5] = 150;
    dw_list[6] = 4097; dh_list[6] = 2;    n_list[6] = 100;
    for (int p = 7; p < PHASES; p++) begin
      dw_list[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                               : $urandom_range(1, 4096);
      dh_list[p] = ($urandom_range(0, 3) == 0) ? $urandom_range(4097, 8191)
                                               : $urandom_range(1, 4096);
      n_list[p] = 146;
    end

    // synchronous reset
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) send_blit(rows[i].q, rows[i].typed, rows[i].r);
    req_valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_dest(dw_list[p], dh_list[p]);
      in_quiet = ($urandom_range(0, 3) == 0);
      out_quiet = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < n_list[p]; n++) begin
        if (p == 0 && n == 0)
          // open the saturation run on an empty box
          send_blit(mk_req(1, 1, 0, 0, 4095, 4095, 4096, 4096, 0, 0), 1'b0, none);
        else
          send_blit(random_blit(p == 0), 1'b0, none);
      end
      req_valid <= 1'b0;
    end

    // let the pipe empty, then wait on for stray beats
    wait_drained();
    repeat (16) @(posedge clk);
    if (pending_q.size() != 0) flag_error("results still outstanding at end of run");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
